FILE: rtl/core/cfa_pkg.sv
package cfa_pkg;

  localparam int DataW = 64;
  localparam int OpW   = 4;
  localparam int InW   = 136;
  localparam int OutW  = 72;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_POW = 4'd5,
    OP_LT  = 4'd6,
    OP_LE  = 4'd7,
    OP_GT  = 4'd8,
    OP_GE  = 4'd9,
    OP_EQ  = 4'd10,
    OP_NE  = 4'd11,
    OP_AND = 4'd12,
    OP_OR  = 4'd13
  } op_t;

  // per-beat context travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             fold;
    logic             is_div;
    logic             is_mod;
    logic             is_mul;
    logic             neg_q;
    logic             neg_r;
    logic [DataW-1:0] res;
  } ctx_t;

endpackage

FILE: rtl/core/cfa_mul_stage.sv
module cfa_mul_stage (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cfa_pkg::DataW-1:0] a,
  input  logic [cfa_pkg::DataW-1:0] b,
  output logic [cfa_pkg::DataW-1:0] p
);
  import cfa_pkg::*;

  logic [DataW-1:0] ll_r, lh_r, hl_r;
  logic [DataW-1:0] lh_s, hl_s;

  // low 64 bits from three 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh_r <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
      hl_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    end
  end

  assign lh_s = {lh_r[31:0], 32'd0};
  assign hl_s = {hl_r[31:0], 32'd0};
  assign p    = ll_r + lh_s + hl_s;

endmodule

FILE: rtl/core/cfa_div_cell.sv
module cfa_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cfa_pkg::ctx_t             ctx_i,
  input  logic [cfa_pkg::DataW-1:0] rem_i,
  input  logic [cfa_pkg::DataW-1:0] quo_i,
  input  logic [cfa_pkg::DataW-1:0] dvs_i,
  output cfa_pkg::ctx_t             ctx_o,
  output logic [cfa_pkg::DataW-1:0] rem_o,
  output logic [cfa_pkg::DataW-1:0] quo_o,
  output logic [cfa_pkg::DataW-1:0] dvs_o
);
  import cfa_pkg::*;

  logic [DataW:0]   trial;
  logic [DataW-1:0] rem_nxt, quo_nxt;
  ctx_t             ctx_r;
  logic [DataW-1:0] rem_r, quo_r, dvs_r;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, quo_i[DataW-1]} - {1'b0, dvs_i};
    if (!trial[DataW]) begin
      rem_nxt = trial[DataW-1:0];
      quo_nxt = {quo_i[DataW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_i[DataW-2:0], quo_i[DataW-1]};
      quo_nxt = {quo_i[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
      dvs_r <= '0;
    end else if (en) begin
      ctx_r <= ctx_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign ctx_o = ctx_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dvs_o = dvs_r;

endmodule

FILE: rtl/core/constant_fold_alu.sv
// each input beat passes through 64 divider cells and one output register;
//   the product joins its beat at the second cell
// throughput: one beat per cycle; the whole chain advances when the output
//   register is free or being taken
// reset: rst_n synchronous active low clears all valid flags
module constant_fold_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // opcode[3:0], left_value[67:4], right_value[131:68],
  // left_is_constant[132], right_is_constant[133]
  input  logic [cfa_pkg::InW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // folded[0], result_value[64:1]
  output logic [cfa_pkg::OutW-1:0] out_tdata
);
  import cfa_pkg::*;

  localparam int Cells = DataW;

  logic [OpW-1:0]   op;
  logic [DataW-1:0] a, b, ma, mb, mul_p;
  logic             ok, sa, sb, adv;
  logic             lt_ab, lt_ba;
  ctx_t             c0;
  ctx_t             ctx_m;

  ctx_t             ctx_w [Cells+1];
  logic [DataW-1:0] rem_w [Cells+1];
  logic [DataW-1:0] quo_w [Cells+1];
  logic [DataW-1:0] dvs_w [Cells+1];

  logic             ov_r;
  logic [OutW-1:0]  od_r;
  logic [DataW-1:0] fin;
  logic [DataW-1:0] rem_s;
  logic [DataW-1:0] res_f;

  assign op  = in_tdata[3:0];
  assign a   = in_tdata[67:4];
  assign b   = in_tdata[131:68];
  assign sa  = a[DataW-1];
  assign sb  = b[DataW-1];
  assign ma  = sa ? (~a + 64'd1) : a;
  assign mb  = sb ? (~b + 64'd1) : b;
  assign ok  = in_tdata[132] & in_tdata[133];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    c0        = '0;
    c0.vld    = in_tvalid;
    c0.fold   = ok;
    c0.neg_q  = sa ^ sb;
    c0.neg_r  = sa;
    case (op)
      OP_ADD: c0.res = a + b;
      OP_SUB: c0.res = a - b;
      OP_MUL: c0.is_mul = 1'b1;
      OP_DIV: begin
        c0.is_div = 1'b1;
        c0.fold   = ok && (b != '0);
      end
      OP_MOD: begin
        c0.is_mod = 1'b1;
        c0.fold   = ok && (b != '0);
      end
      OP_LT:  c0.res = {63'd0, lt_ab};
      OP_LE:  c0.res = {63'd0, !lt_ba};
      OP_GT:  c0.res = {63'd0, lt_ba};
      OP_GE:  c0.res = {63'd0, !lt_ab};
      OP_EQ:  c0.res = {63'd0, a == b};
      OP_NE:  c0.res = {63'd0, a != b};
      OP_AND: c0.res = {63'd0, (a != '0) && (b != '0)};
      OP_OR:  c0.res = {63'd0, (a != '0) || (b != '0)};
      default: c0.fold = 1'b0;
    endcase
  end

  assign ctx_w[0] = c0;
  assign rem_w[0] = '0;
  assign quo_w[0] = ma;
  assign dvs_w[0] = mb;

  // mul_p belongs to the beat now in cell 0's output
  always_comb begin
    ctx_m = ctx_w[1];
    if (ctx_w[1].is_mul) begin
      ctx_m.res = mul_p;
    end
  end

  genvar i;
  generate
    for (i = 0; i < Cells; i++) begin : g_cell
      cfa_div_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .ctx_i ((i == 1) ? ctx_m : ctx_w[i]),
        .rem_i (rem_w[i]),
        .quo_i (quo_w[i]),
        .dvs_i (dvs_w[i]),
        .ctx_o (ctx_w[i+1]),
        .rem_o (rem_w[i+1]),
        .quo_o (quo_w[i+1]),
        .dvs_o (dvs_w[i+1])
      );
    end
  endgenerate

  cfa_mul_stage u_mul (
    .clk (clk),
    .en  (adv),
    .a   (a),
    .b   (b),
    .p   (mul_p)
  );

  assign rem_s = ctx_w[Cells].neg_r ? (~rem_w[Cells] + 64'd1) : rem_w[Cells];

  always_comb begin
    fin = ctx_w[Cells].res;
    if (ctx_w[Cells].is_div) begin
      fin = ctx_w[Cells].neg_q ? (~quo_w[Cells] + 64'd1) : quo_w[Cells];
    end else if (ctx_w[Cells].is_mod) begin
      fin = rem_s;
    end
  end

  assign res_f = ctx_w[Cells].fold ? fin : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= ctx_w[Cells].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od_r <= {7'd0, res_f, ctx_w[Cells].fold};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata);
  endproperty
  a_hold: assert property (p_hold) else $error("output beat changed under stall");

  property p_nofold_zero;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tdata[0] |-> out_tdata[64:1] == '0;
  endproperty
  a_nofold_zero: assert property (p_nofold_zero) else $error("unfolded result nonzero");

  property p_ready;
    @(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready;
  endproperty
  a_ready: assert property (p_ready) else $error("stalled with empty output");

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  localparam int NumRandom = 1680;
  localparam longint CycleLimit = 400000;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic        fold;
    logic [63:0] value;
  } fold_res_t;

  class fold_scoreboard;
    fold_res_t pending[$];
    int errors;
    int seen;
    int folds;

    function fold_res_t evaluate(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                 logic lc, logic rc);
      fold_res_t r;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      sa = a;
      sb = b;
      r.fold = lc && rc;
      r.value = '0;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      if (r.fold) begin
        case (op)
          OP_ADD: r.value = a + b;
          OP_SUB: r.value = a - b;
          OP_MUL: r.value = a * b;
          OP_DIV: begin
            if (b == 0) r.fold = 1'b0;
            else begin
              q = ma / mb;
              r.value = (a[63] ^ b[63]) ? -q : q;
            end
          end
          OP_MOD: begin
            if (b == 0) r.fold = 1'b0;
            else begin
              q = ma % mb;
              r.value = a[63] ? -q : q;
            end
          end
          OP_LT: r.value = {63'd0, sa < sb};
          OP_LE: r.value = {63'd0, sa <= sb};
          OP_GT: r.value = {63'd0, sa > sb};
          OP_GE: r.value = {63'd0, sa >= sb};
          OP_EQ: r.value = {63'd0, a == b};
          OP_NE: r.value = {63'd0, a != b};
          OP_AND: r.value = {63'd0, (a != 0) && (b != 0)};
          OP_OR: r.value = {63'd0, (a != 0) || (b != 0)};
          default: r.fold = 1'b0;
        endcase
      end
      if (!r.fold) r.value = '0;
      return r;
    endfunction

    function void note_input(logic [InW-1:0] d);
      pending.push_back(evaluate(d[3:0], d[67:4], d[131:68], d[132], d[133]));
    endfunction

    task automatic report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task automatic check_result(logic [OutW-1:0] d);
      fold_res_t e;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %h", d));
        return;
      end
      e = pending.pop_front();
      if (e.fold) folds++;
      if (d[0] !== e.fold)
        report($sformatf("beat %0d folded %b want %b", seen, d[0], e.fold));
      if (d[64:1] !== e.value)
        report($sformatf("beat %0d value %h want %h", seen, d[64:1], e.value));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [InW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OutW-1:0] out_tdata;

  fold_scoreboard sb;
  longint cycles;
  bit hold_off;
  bit stim_done;
  int sent;

  constant_fold_alu u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial cycles = 0;

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return MinVal;
      2: return MaxVal;
      3: return 64'hffff_ffff_ffff_ffff;
      4: return 64'(signed'($urandom_range(0, 40)) - 20);
      5: return {32'd0, $urandom()};
      6: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_beat(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                           logic lc, logic rc);
    int gap;
    gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, rc, lc, b, a, op};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic random_beat();
    logic [63:0] b;
    logic [3:0] op;
    op = 4'($urandom_range(0, 15));
    b = pick_value();
    if ($urandom_range(0, 3) == 0) b = '0;
    send_beat(op, pick_value(), b, $urandom_range(0, 9) != 0,
              $urandom_range(0, 9) != 0);
  endtask

  // receiver: random stalls, plus one long hold-off while input keeps coming
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else begin
        gap = $urandom_range(0, 2) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    wait (rst_n);
    wait (sent == 600);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    sent = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    for (int op = 0; op < 16; op++)
      send_beat(4'(op), MinVal, 64'hffff_ffff_ffff_ffff, 1, 1);
    send_beat(OP_DIV, 64'd7, 64'd0, 1, 1);
    send_beat(OP_MOD, MinVal, 64'd0, 1, 1);
    send_beat(OP_MOD, -64'sd7, 64'd2, 1, 1);
    send_beat(OP_DIV, 64'd7, -64'sd2, 1, 1);
    send_beat(OP_ADD, MaxVal, 64'd1, 1, 1);
    send_beat(OP_MUL, MaxVal, MaxVal, 1, 1);
    send_beat(OP_ADD, 64'd1, 64'd2, 0, 1);
    send_beat(OP_SUB, 64'd1, 64'd2, 1, 0);
    send_beat(OP_LT, MinVal, MaxVal, 1, 1);
    for (int i = 0; i < NumRandom; i++) random_beat();
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d beats sent, %0d results checked, %0d folded", sent, sb.seen, sb.folds);
    $display("all opcodes, flags, zero divisors, min/-1 and a long output stall covered");
    if (sb.errors == 0 && sb.seen == sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
